@@ src/bounded_task_queue_controller_macros.svh @@
`ifndef BOUNDED_TASK_QUEUE_CONTROLLER_MACROS_SVH
`define BOUNDED_TASK_QUEUE_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BTQC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btqc assertion failed");

// next-cycle implication, checked outside reset
`define BTQC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btqc assertion failed");

`endif

@@ src/btqc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package btqc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH = 32;
    localparam int SEQUENCE_WIDTH = 48;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam int LIMIT_W = 5;
    localparam int COUNT_FIELD_W = 5;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_POST      = 3'd1;
    localparam logic [2:0] OP_POST_CONT = 3'd2;
    localparam logic [2:0] OP_STOP      = 3'd3;
    localparam logic [2:0] OP_POP       = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_RUNNING = 3'd1;
    localparam logic [2:0] ST_OVERFLOW    = 3'd2;
    localparam logic [2:0] ST_REFUSED     = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_RUN      = 2'd1;
    localparam logic [1:0] ACT_CANCEL   = 2'd2;
    localparam logic [1:0] ACT_TEARDOWN = 2'd3;

    localparam logic [1:0] LC_NEW       = 2'd0;
    localparam logic [1:0] LC_RUNNING   = 2'd1;
    localparam logic [1:0] LC_QUIESCING = 2'd2;
    localparam logic [1:0] LC_STOPPED   = 2'd3;

    typedef struct packed {
        logic [2:0]           operation;
        logic [TAG_WIDTH-1:0] task_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]                status;
        logic [SEQUENCE_WIDTH-1:0] sequence_number;
        logic [COUNT_FIELD_W-1:0]  overflow_depth;
        logic [1:0]                pop_action;
        logic [TAG_WIDTH-1:0]      popped_tag;
        logic [SEQUENCE_WIDTH-1:0] popped_sequence;
        logic [1:0]                lifecycle;
        logic [COUNT_FIELD_W-1:0]  pending_count;
        logic                      continuation_waiting;
    } t_out_item;

    typedef struct packed {
        logic                      is_cont;
        logic [SEQUENCE_WIDTH-1:0] seq;
        logic [TAG_WIDTH-1:0]      tag;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] addr;
        t_slot            data;
    } t_slot_wr;

endpackage

`default_nettype wire

@@ src/btqc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module btqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/btqc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_task_queue_controller_macros.svh"

module btqc_core
    import btqc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_commit,
    input  wire t_in_item           i_item,
    input  wire t_slot              i_slot,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output logic      [PTR_W-1:0]   o_head,
    output t_slot_wr                o_wr,
    output t_out_item               o_result
);

    logic [PTR_W-1:0]          r_head, n_head;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [SEQUENCE_WIDTH-1:0] r_next_seq, n_next_seq;
    logic [1:0]                r_lc, n_lc;
    logic                      r_td, n_td;
    logic                      r_cp, n_cp;
    logic [SEQUENCE_WIDTH-1:0] r_cs, n_cs;

    logic [CMP_W-1:0] eff_limit;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail;
    logic             is_cont;

    always_comb begin
        eff_limit = (CMP_W'(i_limit) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                           : CMP_W'(i_limit);
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail = PTR_W'(tail_sum);
        is_cont = (i_item.operation == OP_POST_CONT);

        n_head = r_head;
        n_count = r_count;
        n_next_seq = r_next_seq;
        n_lc = r_lc;
        n_td = r_td;
        n_cp = r_cp;
        n_cs = r_cs;
        o_result = '0;
        o_wr.we = 1'b0;
        o_wr.addr = tail;
        o_wr.data.is_cont = is_cont;
        o_wr.data.seq = r_next_seq;
        o_wr.data.tag = i_item.task_tag;

        unique case (i_item.operation)
            OP_START: begin
                if (r_lc != LC_NEW || i_limit == '0) begin
                    o_result.status = ST_REFUSED;
                end else begin
                    n_lc = LC_RUNNING;
                end
            end
            OP_POST, OP_POST_CONT: begin
                priority if (r_lc != LC_RUNNING) begin
                    o_result.status = ST_NOT_RUNNING;
                end else if (is_cont && r_cp) begin
                    o_result.sequence_number = r_cs;
                end else if (CMP_W'(r_count) >= eff_limit
                             || CMP_W'(r_count) >= CMP_W'(QUEUE_DEPTH)) begin
                    o_result.status = ST_OVERFLOW;
                    o_result.overflow_depth = COUNT_FIELD_W'(r_count);
                end else begin
                    o_result.sequence_number = r_next_seq;
                    n_next_seq = r_next_seq + 1'b1;
                    o_wr.we = i_commit;
                    n_count = r_count + 1'b1;
                    if (is_cont) begin
                        n_cp = 1'b1;
                        n_cs = r_next_seq;
                    end
                end
            end
            OP_STOP: begin
                if (r_lc != LC_RUNNING) begin
                    o_result.status = ST_NOT_RUNNING;
                end else begin
                    n_lc = LC_QUIESCING;
                end
            end
            OP_POP: begin
                priority if (r_count != '0) begin
                    o_result.popped_tag = i_slot.tag;
                    o_result.popped_sequence = i_slot.seq;
                    if (i_slot.is_cont) begin
                        n_cp = 1'b0;
                        n_cs = '0;
                    end
                    n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                    o_result.pop_action = (r_lc == LC_QUIESCING) ? ACT_CANCEL : ACT_RUN;
                end else if (r_lc == LC_QUIESCING && !r_td) begin
                    n_td = 1'b1;
                    n_lc = LC_STOPPED;
                    o_result.pop_action = ACT_TEARDOWN;
                end else begin
                    o_result.status = ST_EMPTY;
                end
            end
            default: begin
                o_result.status = ST_REFUSED;
            end
        endcase

        o_result.lifecycle = n_lc;
        o_result.pending_count = COUNT_FIELD_W'(n_count);
        o_result.continuation_waiting = n_cp;
    end

    assign o_head = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
            r_next_seq <= SEQUENCE_WIDTH'(1);
            r_lc <= LC_NEW;
            r_td <= 1'b0;
            r_cp <= 1'b0;
            r_cs <= '0;
        end else if (i_commit) begin
            r_head <= n_head;
            r_count <= n_count;
            r_next_seq <= n_next_seq;
            r_lc <= n_lc;
            r_td <= n_td;
            r_cp <= n_cp;
            r_cs <= n_cs;
        end
    end

    `BTQC_ASSERT_NOW(a_count_bound, 1'b1, CMP_W'(r_count) <= CMP_W'(QUEUE_DEPTH))
    `BTQC_ASSERT_NOW(a_cont_seq_clear, !r_cp, r_cs == '0)
    `BTQC_ASSERT_NOW(a_stopped_empty, r_lc == LC_STOPPED, r_count == '0 && r_td)
    `BTQC_ASSERT_NEXT(a_post_grows, o_wr.we, r_count == CNT_W'($past(r_count) + 1'b1))

endmodule

`default_nettype wire

@@ src/bounded_task_queue_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Command queue with admission control and a new/running/quiescing/stopped lifecycle.
// Every transaction gives exactly one result transaction. A transaction is taken in
// the idle state, where the head entry of the slot memory is read (registered read);
// in the execute state the core computes the result, updates the state and writes a
// posted task back. The input stall stays high while in the execute state, so a new
// transaction is taken only after the last one completes. A result waits in an output
// register, and the next transaction is taken while it waits; only completing that
// next transaction waits for the output register to free up. queue_limit is written
// through the configuration channel, which is always ready, and values above the
// queue depth act as the depth.

module bounded_task_queue_controller
    import btqc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire t_in_item           i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output t_out_item               o_out_item,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    output logic                    o_cfg_ready
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state           r_state;
    t_in_item         r_item;
    logic [LIMIT_W-1:0] r_limit;
    logic             commit;
    logic [PTR_W-1:0] head;
    t_slot_wr         slot_wr;
    t_out_item        result;
    logic [SLOT_W-1:0] rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign commit = (r_state == S_EXEC) && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                    if (o_out_valid && !i_out_stall) begin
                        o_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                        o_out_valid <= 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_out_item <= result;
        end
    end

    btqc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_wr.we),
        .i_waddr (slot_wr.addr),
        .i_wdata (slot_wr.data),
        .i_raddr (head),
        .o_rdata (rdata)
    );

    btqc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_item   (r_item),
        .i_slot   (t_slot'(rdata)),
        .i_limit  (r_limit),
        .o_head   (head),
        .o_wr     (slot_wr),
        .o_result (result)
    );

endmodule

`default_nettype wire
